// ----- hw/rtl/texture_byte_size_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Texture byte size unit: assertion macros
// Short forms for the concurrent assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_BYTE_SIZE_UNIT_MACROS_SVH
`define TEXTURE_BYTE_SIZE_UNIT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define TBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that is checked at every edge, reset included.
`define TBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Texture byte size package
// Shared widths, codes, the queued item type and the block size table.
// ----------------------------------------------------------------------------
`default_nettype none

package tbs_pkg;

    localparam int MAX_MIP_LEVELS = 15;
    localparam int FORMAT_COUNT   = 100;

    localparam int W_DIM   = 15;
    localparam int W_FMT   = 7;
    localparam int W_MIP   = 4;
    localparam int W_ARR   = 12;
    localparam int W_BPB   = 9;
    localparam int W_SIZE  = 45;
    localparam int W_PITCH = 24;
    localparam int W_MRP   = 16;
    localparam int W_MLB   = 24;

    localparam logic [W_FMT-1:0] BC_FIRST = 7'd70;
    localparam logic [W_FMT-1:0] BC_LAST  = 7'd84;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_TEXTURE = 1'b0;
    localparam logic OP_SURFACE = 1'b1;

    localparam logic CFG_MIN_ROW_PITCH   = 1'b0;
    localparam logic CFG_MIN_LEVEL_BYTES = 1'b1;

    typedef enum logic [2:0] {
        K_ERROR,
        K_ZERO,
        K_SURF_BC,
        K_SURF_LIN,
        K_TEX_BC,
        K_TEX_LIN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [W_DIM-1:0]   width;
        logic [W_DIM-1:0]   height;
        logic [W_BPB-1:0]   bytes;
        logic [W_MIP-1:0]   mips;
        logic [W_MIP-1:0]   levels;
        logic [W_ARR-1:0]   arrays;
    } t_item;

    // Bytes per 4x4 pixel block for each format code.
    function automatic logic [W_BPB-1:0] block_bytes(input logic [W_FMT-1:0] fmt);
        logic [W_BPB-1:0] b;
        priority if (fmt == 7'd0)  b = 9'd0;
        else if (fmt <= 7'd4)      b = 9'd256;
        else if (fmt <= 7'd8)      b = 9'd192;
        else if (fmt <= 7'd22)     b = 9'd128;
        else if (fmt <= 7'd47)     b = 9'd64;
        else if (fmt <= 7'd59)     b = 9'd32;
        else if (fmt <= 7'd65)     b = 9'd16;
        else if (fmt == 7'd66)     b = 9'd2;
        else if (fmt <= 7'd69)     b = 9'd64;
        else if (fmt <= 7'd72)     b = 9'd8;
        else if (fmt <= 7'd78)     b = 9'd16;
        else if (fmt <= 7'd81)     b = 9'd8;
        else if (fmt <= 7'd84)     b = 9'd16;
        else if (fmt <= 7'd86)     b = 9'd32;
        else if (fmt <= 7'd93)     b = 9'd64;
        else                       b = 9'd0;
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbs_front.sv -----
// ----------------------------------------------------------------------------
// Texture byte size front end
// Takes input beats, looks up the block size and sorts each item by the work
// it needs before it goes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_front import tbs_pkg::*; (
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_operation,
    input  wire logic [W_DIM-1:0] i_width,
    input  wire logic [W_DIM-1:0] i_height,
    input  wire logic [W_FMT-1:0] i_format,
    input  wire logic [W_MIP-1:0] i_mip_levels,
    input  wire logic [W_ARR-1:0] i_array_count,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output t_item                 o_item
);

    logic             bc;
    logic [W_MIP-1:0] mips_sat;
    t_kind            kind;

    always_comb begin
        bc       = (i_format >= BC_FIRST) && (i_format <= BC_LAST);
        mips_sat = (i_mip_levels > W_MIP'(MAX_MIP_LEVELS)) ? W_MIP'(MAX_MIP_LEVELS)
                                                           : i_mip_levels;
        priority if ({1'b0, i_format} >= (W_FMT+1)'(FORMAT_COUNT)) kind = K_ERROR;
        else if (i_operation == OP_SURFACE && bc) kind = K_SURF_BC;
        else if (i_operation == OP_SURFACE)       kind = K_SURF_LIN;
        else if (bc)                              kind = K_TEX_BC;
        else if (mips_sat != '0)                  kind = K_TEX_LIN;
        else                                      kind = K_ZERO;

        o_item.kind   = kind;
        o_item.width  = i_width;
        o_item.height = i_height;
        o_item.bytes  = block_bytes(i_format);
        o_item.mips   = mips_sat;
        o_item.arrays = i_array_count;
        // A compressed texture with no mip count still sizes its top level.
        if (kind == K_TEX_BC) begin
            o_item.levels = (mips_sat == '0) ? W_MIP'(1) : mips_sat;
        end else begin
            o_item.levels = W_MIP'(1);
        end
    end

    assign o_push     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

endmodule

`default_nettype wire

// ----- hw/rtl/tbs_queue.sv -----
// ----------------------------------------------------------------------------
// Texture byte size item queue
// Short first-in first-out store between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_queue import tbs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    input  wire logic i_pop,
    output t_item     o_item,
    output logic      o_full,
    output logic      o_empty
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QPTR_W-1:0]  n_wp;
    logic [QPTR_W-1:0]  n_rp;

    assign n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
    assign n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/tbs_back.sv -----
// ----------------------------------------------------------------------------
// Texture byte size engine
// Works one queued item at a time: a three-stage pipeline over the mip levels
// of compressed formats, a multiply chain and a serial divide by twelve for
// the mip series of other formats, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_back import tbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    input  wire logic [W_MRP-1:0]   i_min_row_pitch,
    input  wire logic [W_MLB-1:0]   i_min_level_bytes,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [W_SIZE-1:0]       o_byte_size,
    output logic [W_PITCH-1:0]      o_row_pitch,
    output logic                    o_row_pitch_valid,
    output logic                    o_format_error
);

    localparam int BLK_W     = W_DIM - 2;
    localparam int LSZ_W     = W_PITCH + BLK_W;
    localparam int SUM_W     = LSZ_W + W_MIP;
    localparam int ACC_W     = SUM_W + W_ARR;
    localparam int WH_W      = 2 * W_DIM;
    localparam int WB_W      = WH_W + W_BPB;
    localparam int PROD_W    = WB_W + W_ARR;
    localparam int DIV_STEPS = (PROD_W - 2 + 3) / 4;
    localparam int DIV_W     = DIV_STEPS * 4;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_WH,
        S_MUL_B,
        S_MUL_A,
        S_SER,
        S_DIV,
        S_LVL,
        S_DONE
    } t_state;

    t_state               r_state;
    t_item                r_item;
    logic [W_DIM-1:0]     r_lw;
    logic [W_DIM-1:0]     r_lh;
    logic [W_MIP-1:0]     r_iss;
    logic                 r_v1;
    logic                 r_v2;
    logic [W_PITCH-1:0]   r_pitch;
    logic [BLK_W-1:0]     r_lhq;
    logic [LSZ_W-1:0]     r_lsz;
    logic [ACC_W-1:0]     r_acc;
    logic [DIV_W-1:0]     r_div;
    logic [1:0]           r_rem;
    logic [DCNT_W-1:0]    r_dcnt;

    logic                 r_out_valid;
    logic [W_SIZE-1:0]    r_byte_size;
    logic [W_PITCH-1:0]   r_row_pitch;
    logic                 r_row_pitch_valid;
    logic                 r_format_error;

    // Level pipeline
    logic [BLK_W-1:0]         lwq;
    logic [BLK_W-1:0]         lhq;
    logic [BLK_W+W_BPB-1:0]   pitch_raw;
    logic [W_PITCH-1:0]       n_pitch;
    logic [BLK_W-1:0]         n_lhq;
    logic [LSZ_W-1:0]         lvl_prod;
    logic [LSZ_W-1:0]         lvl_floor;
    logic [LSZ_W-1:0]         n_lsz;
    logic [ACC_W-1:0]         n_acc_lvl;
    logic                     issue_left;

    // Multiply chain and series
    logic [WH_W-1:0]          n_wh;
    logic [WB_W-1:0]          n_wb;
    logic [ACC_W-1:0]         n_arr;
    logic [PROD_W-1:0]        ser_p;
    logic [4:0]               ser_sh;
    logic [PROD_W-1:0]        ser_s;
    logic                     ser_nz;
    logic [PROD_W-1:0]        ser_x;
    logic [DIV_W-1:0]         n_div_init;

    // Divide by three, one nibble a cycle
    logic [5:0]               dv;
    logic [11:0]              dv_mul;
    logic [3:0]               dq;
    logic [5:0]               dr;

    // Result selection
    logic [W_SIZE-1:0]        n_size;
    logic [W_PITCH-1:0]       n_row_pitch;
    logic                     n_pv;
    logic                     n_ferr;

    always_comb begin
        lwq       = r_lw[W_DIM-1:2];
        lhq       = r_lh[W_DIM-1:2];
        pitch_raw = ((lwq == '0) ? BLK_W'(1) : lwq) * r_item.bytes;
        n_pitch   = (W_PITCH'(pitch_raw) > W_PITCH'(i_min_row_pitch))
                    ? W_PITCH'(pitch_raw) : W_PITCH'(i_min_row_pitch);
        n_lhq     = (lhq == '0) ? BLK_W'(1) : lhq;

        lvl_prod  = r_pitch * r_lhq;
        // The single surface size takes no lower bound on the level size.
        lvl_floor = (r_item.kind == K_TEX_BC) ? LSZ_W'(i_min_level_bytes) : '0;
        n_lsz     = (lvl_prod > lvl_floor) ? lvl_prod : lvl_floor;
        n_acc_lvl = r_acc + ACC_W'(r_lsz);
        issue_left = (r_iss != r_item.levels);

        n_wh  = r_item.width * r_item.height;
        n_wb  = r_acc[WH_W-1:0] * r_item.bytes;
        n_arr = r_acc[SUM_W-1:0] * r_item.arrays;

        // floor(p*(4^m-1)/(12*4^m)) = floor((p - p/4^m - carry)/12), where the
        // carry is set when the shifted-out part is not zero.
        ser_p      = r_acc[PROD_W-1:0];
        ser_sh     = {r_item.mips, 1'b0};
        ser_s      = ser_p >> ser_sh;
        ser_nz     = ((ser_s << ser_sh) != ser_p);
        ser_x      = ser_p - ser_s - PROD_W'(ser_nz);
        n_div_init = DIV_W'(ser_x[PROD_W-1:2]);

        // v stays below 48, so v*43/128 gives v/3 exactly.
        dv     = {r_rem, r_div[DIV_W-1 -: 4]};
        dv_mul = {6'b0, dv} * 12'd43;
        dq     = dv_mul[10:7];
        dr     = dv - {1'b0, dq, 1'b0} - {2'b0, dq};

        n_size      = '0;
        n_row_pitch = '0;
        n_pv        = 1'b0;
        n_ferr      = 1'b0;
        unique case (r_item.kind)
            K_SURF_BC: begin
                n_size      = r_acc[W_SIZE-1:0];
                n_row_pitch = r_pitch;
                n_pv        = 1'b1;
            end
            K_TEX_BC:   n_size = r_acc[W_SIZE-1:0];
            K_SURF_LIN: n_size = r_acc[W_SIZE+3:4];
            K_TEX_LIN:  n_size = r_div[W_SIZE-1:0];
            K_ERROR:    n_ferr = 1'b1;
            K_ZERO:     n_size = '0;
            default:    n_size = '0;
        endcase
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_item <= i_q_item;
                        r_lw   <= i_q_item.width;
                        r_lh   <= i_q_item.height;
                        r_iss  <= '0;
                        r_acc  <= '0;
                        r_v1   <= 1'b0;
                        r_v2   <= 1'b0;
                        unique case (i_q_item.kind)
                            K_SURF_BC, K_TEX_BC:    r_state <= S_LVL;
                            K_SURF_LIN, K_TEX_LIN:  r_state <= S_MUL_WH;
                            K_ERROR, K_ZERO:        r_state <= S_DONE;
                            default:                r_state <= S_DONE;
                        endcase
                    end
                end
                S_MUL_WH: begin
                    r_acc   <= ACC_W'(n_wh);
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_acc   <= ACC_W'(n_wb);
                    r_state <= (r_item.kind == K_SURF_LIN) ? S_DONE : S_MUL_A;
                end
                S_MUL_A: begin
                    r_acc   <= n_arr;
                    r_state <= (r_item.kind == K_TEX_LIN) ? S_SER : S_DONE;
                end
                S_SER: begin
                    r_div   <= n_div_init;
                    r_rem   <= 2'd0;
                    r_dcnt  <= DCNT_W'(DIV_STEPS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_div  <= {r_div[DIV_W-5:0], dq};
                    r_rem  <= dr[1:0];
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_LVL: begin
                    // Stage one: pitch of the level, stage two: level size,
                    // stage three: running sum.
                    r_v1 <= issue_left;
                    if (issue_left) begin
                        r_pitch <= n_pitch;
                        r_lhq   <= n_lhq;
                        r_lw    <= r_lw >> 1;
                        r_lh    <= r_lh >> 1;
                        r_iss   <= r_iss + W_MIP'(1);
                    end
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_lsz <= n_lsz;
                    end
                    if (r_v2) begin
                        r_acc <= n_acc_lvl;
                    end
                    if (!issue_left && !r_v1 && !r_v2) begin
                        r_state <= (r_item.kind == K_TEX_BC) ? S_MUL_A : S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid       <= 1'b1;
                        r_byte_size       <= n_size;
                        r_row_pitch       <= n_row_pitch;
                        r_row_pitch_valid <= n_pv;
                        r_format_error    <= n_ferr;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_size       = r_byte_size;
    assign o_row_pitch       = r_row_pitch;
    assign o_row_pitch_valid = r_row_pitch_valid;
    assign o_format_error    = r_format_error;

endmodule

`default_nettype wire

// ----- hw/rtl/texture_byte_size_unit.sv -----
// ----------------------------------------------------------------------------
// Texture byte size unit
// Byte size of a whole texture with mips and array slices, or of one surface
// with its row pitch.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid with o_in_stall; a beat carries operation, size,
// format, mip count and array count. Output channel: o_out_valid with
// i_out_stall; one result beat per input beat, in order.
// Configuration: i_cfg_valid with o_cfg_ready (always high), index 0 is the
// minimum row pitch and index 1 the minimum level size; write only while idle.
// An accepted beat waits in a two-entry queue; the engine then goes straight
// to its result state for an error or empty result, runs a multiply chain for
// a plain surface, takes one mip level a cycle through its pipeline for a
// compressed texture, and for a plain texture also runs the mip series and a
// divide by twelve at one nibble a cycle. The result then goes into the output register.
// While the receiver stalls, the result holds and the queue keeps taking
// beats until it is full. Synchronous reset empties queue and engine and
// clears both configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_byte_size_unit import tbs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic [W_DIM-1:0]   i_width,
    input  wire logic [W_DIM-1:0]   i_height,
    input  wire logic [W_FMT-1:0]   i_format,
    input  wire logic [W_MIP-1:0]   i_mip_levels,
    input  wire logic [W_ARR-1:0]   i_array_count,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [W_SIZE-1:0]       o_byte_size,
    output logic [W_PITCH-1:0]      o_row_pitch,
    output logic                    o_row_pitch_valid,
    output logic                    o_format_error,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [W_MLB-1:0]   i_cfg_data
);

    logic [W_MRP-1:0] r_min_row_pitch;
    logic [W_MLB-1:0] r_min_level_bytes;

    t_item            front_item;
    t_item            q_item;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_row_pitch   <= '0;
            r_min_level_bytes <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_ROW_PITCH:   r_min_row_pitch   <= i_cfg_data[W_MRP-1:0];
                CFG_MIN_LEVEL_BYTES: r_min_level_bytes <= i_cfg_data;
            endcase
        end
    end

    tbs_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_format      (i_format),
        .i_mip_levels  (i_mip_levels),
        .i_array_count (i_array_count),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    tbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tbs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_item          (q_item),
        .o_q_pop           (pop),
        .i_min_row_pitch   (r_min_row_pitch),
        .i_min_level_bytes (r_min_level_bytes),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_byte_size       (o_byte_size),
        .o_row_pitch       (o_row_pitch),
        .o_row_pitch_valid (o_row_pitch_valid),
        .o_format_error    (o_format_error)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tbs_checker.sv -----
// ----------------------------------------------------------------------------
// Texture byte size checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "texture_byte_size_unit_macros.svh"

module tbs_checker import tbs_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [W_SIZE-1:0]  o_byte_size,
    input wire logic [W_PITCH-1:0] o_row_pitch,
    input wire logic               o_row_pitch_valid,
    input wire logic               o_format_error
);

    `TBS_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    `TBS_ASSERT(a_error_is_empty, i_clk, i_rst_n, o_out_valid && o_format_error |-> (o_byte_size == '0) && !o_row_pitch_valid, "format error with size")

    `TBS_ASSERT(a_pitch_zero, i_clk, i_rst_n, o_out_valid && !o_row_pitch_valid |-> (o_row_pitch == '0), "row pitch without valid")

    `TBS_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_size), "stalled result changed")

endmodule

bind texture_byte_size_unit tbs_checker u_tbs_checker (.*);

`default_nettype wire
